@@ hw/rtl/qsm_pkg.sv @@
// shared types, constants and helper functions for the quadrature speed meter
`timescale 1ns / 1ps
`default_nettype none

package qsm_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam int DIGITS              = 5;

  localparam int SPEED_W  = 16;
  localparam int SCALE_W  = 10;
  localparam int SHIFT_W  = 4;
  localparam int PERIOD_W = 4;
  localparam int POS_W    = 4;
  localparam int CHAR_W   = 8;
  localparam int THR_W    = SPEED_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SCALE_W;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 4'd3;
  localparam logic [SCALE_W-1:0]  SCALE_RESET  = 10'd600;
  localparam logic [SHIFT_W-1:0]  SHIFT_RESET  = 4'd8;
  localparam logic [SPEED_W-1:0]  SPEED_MAX    = 16'hFFFF;
  localparam logic [CHAR_W-1:0]   ASCII_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0]   ASCII_NINE   = 8'h39;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISPLAY_PERIOD = 2'd0,
    REG_SPEED_SCALE    = 2'd1,
    REG_SPEED_SHIFT    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [SPEED_W-1:0] count_now;
    logic               direction_up;
  } in_item_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic               dir_flag;
    logic               char_valid;
    logic [CHAR_W-1:0]  ascii_char;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] display_period;
    logic [SCALE_W-1:0]  speed_scale;
    logic [SHIFT_W-1:0]  speed_shift;
  } cfg_t;

  // one measured tick waiting for the result sequencer
  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic               dir;
    logic               disp;
    logic [SPEED_W-1:0] val;
    logic [POS_W-1:0]   pos;
  } entry_t;

  // m * 10^k, clipped just above the largest speed value
  function automatic logic [THR_W-1:0] dec_thr(input int m, input int k);
    longint p;
    int i;
    p = longint'(m);
    for (i = 0; i < k; i++) begin
      p = p * 10;
      if (p > 65536) p = 65536;
    end
    if (p > 65536) p = 65536;
    return THR_W'(p);
  endfunction

  localparam logic [SPEED_W-1:0] DISP_LIMIT = SPEED_W'(dec_thr(1, DIGITS) - 17'd1);

endpackage

`default_nettype wire

@@ hw/rtl/qsm_front.sv @@
// front end: count difference, scaling, saturation and display tick selection
`timescale 1ns / 1ps
`default_nettype none

module qsm_front #(
  parameter int COUNT_WIDTH = qsm_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  qsm_pkg::in_item_t in_item_i,
  output logic              in_stall_o,
  input  qsm_pkg::cfg_t     cfg_i,
  output logic              push_o,
  output qsm_pkg::entry_t   entry_o,
  input  logic              full_i
);
  import qsm_pkg::*;

  localparam int PROD_W = COUNT_WIDTH + SCALE_W;

  logic [COUNT_WIDTH-1:0] prev_q, prev_d;
  logic [PERIOD_W-1:0]    cnt_q, cnt_d;
  logic [COUNT_WIDTH-1:0] now;
  logic [COUNT_WIDTH-1:0] diff;
  logic [PERIOD_W-1:0]    cnt_dec;
  logic                   disp;

  logic                   s1_valid_q, s1_valid_d;
  logic [COUNT_WIDTH-1:0] s1_diff_q;
  logic                   s1_dir_q;
  logic                   s1_disp_q;

  logic                   s2_valid_q, s2_valid_d;
  logic [PROD_W-1:0]      s2_prod_q;
  logic                   s2_dir_q;
  logic                   s2_disp_q;

  logic                   accept;
  logic                   s1_move;
  logic                   s1_free;
  logic                   s2_free;

  logic [PROD_W-1:0]      shifted;
  logic [SPEED_W-1:0]     speed;
  logic [SPEED_W-1:0]     val;
  logic [POS_W-1:0]       pos;

  assign push_o     = s2_valid_q && !full_i;
  assign s2_free    = !s2_valid_q || push_o;
  assign s1_move    = s1_valid_q && s2_free;
  assign s1_free    = !s1_valid_q || s1_move;
  assign in_stall_o = !s1_free;
  assign accept     = in_valid_i && s1_free;

  // countdown steps first, then reloads on a display tick
  always_comb begin
    now     = COUNT_WIDTH'(in_item_i.count_now);
    diff    = in_item_i.direction_up ? (now - prev_q) : (prev_q - now);
    cnt_dec = (cnt_q != '0) ? (cnt_q - 4'd1) : cnt_q;
    disp    = (cnt_dec == '0);
    cnt_d   = cnt_q;
    prev_d  = prev_q;
    if (accept) begin
      cnt_d  = disp ? cfg_i.display_period : cnt_dec;
      prev_d = now;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
    s2_valid_d = s2_valid_q;
    if (s1_move) begin
      s2_valid_d = 1'b1;
    end else if (push_o) begin
      s2_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= '0;
      cnt_q      <= PERIOD_RESET;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      prev_q     <= prev_d;
      cnt_q      <= cnt_d;
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_diff_q <= diff;
      s1_dir_q  <= in_item_i.direction_up;
      s1_disp_q <= disp;
    end
    if (s1_move) begin
      s2_prod_q <= PROD_W'(s1_diff_q) * PROD_W'(cfg_i.speed_scale);
      s2_dir_q  <= s1_dir_q;
      s2_disp_q <= s1_disp_q;
    end
  end

  // shift, saturate, clamp for display and find the leading digit position
  always_comb begin
    shifted = s2_prod_q >> cfg_i.speed_shift;
    speed   = (|shifted[PROD_W-1:SPEED_W]) ? SPEED_MAX : shifted[SPEED_W-1:0];
    val     = (speed > DISP_LIMIT) ? DISP_LIMIT : speed;
    pos     = '0;
    for (int k = 1; k < DIGITS; k++) begin
      if ({1'b0, val} >= dec_thr(1, k)) pos = pos + 4'd1;
    end
  end

  always_comb begin
    entry_o.speed = speed;
    entry_o.dir   = s2_dir_q;
    entry_o.disp  = s2_disp_q;
    entry_o.val   = val;
    entry_o.pos   = pos;
  end

endmodule

`default_nettype wire

@@ hw/rtl/qsm_queue.sv @@
// small first-in first-out queue of measured ticks between front and back
`timescale 1ns / 1ps
`default_nettype none

module qsm_queue #(
  parameter int DEPTH = qsm_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  qsm_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output qsm_pkg::entry_t entry_o,
  output logic            empty_o
);
  import qsm_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  entry_t             mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_q, wr_d;
  logic [PTR_W-1:0]   rd_q, rd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == FULL_CNT);
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LAST_PTR) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == LAST_PTR) ? '0 : rd_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/qsm_back.sv @@
// back end: emits one result item per cycle while its output is not stalled, decimal digits most significant first
`timescale 1ns / 1ps
`default_nettype none

module qsm_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  output logic               pop_o,
  input  qsm_pkg::entry_t    entry_i,
  input  logic               empty_i,
  output logic               out_valid_o,
  output qsm_pkg::out_item_t out_item_o,
  input  logic               out_stall_i
);
  import qsm_pkg::*;

  localparam int NPOS = 2 ** POS_W;

  logic               busy_q, busy_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_item_q;
  logic [SPEED_W-1:0] speed_q;
  logic               dir_q;
  logic               disp_q;
  logic [SPEED_W-1:0] val_q;
  logic [POS_W-1:0]   pos_q;

  logic [THR_W-1:0]   thr_tab [NPOS][10];
  logic [8:0]         ge;
  logic [3:0]         digit;
  logic [THR_W-1:0]   sub;
  logic [THR_W-1:0]   rem;
  logic               out_free;
  logic               emit;
  logic               last_now;
  out_item_t          res;

  // multiples of each power of ten, a constant table
  for (genvar k = 0; k < NPOS; k++) begin : g_pos
    for (genvar m = 0; m < 10; m++) begin : g_mul
      assign thr_tab[k][m] = dec_thr(m, k);
    end
  end

  always_comb begin
    for (int m = 1; m < 10; m++) begin
      ge[m-1] = ({1'b0, val_q} >= thr_tab[pos_q][m]);
    end
    digit = 4'($countones(ge));
    sub   = thr_tab[pos_q][digit];
    rem   = {1'b0, val_q} - sub;
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign emit     = busy_q && out_free;
  assign last_now = !disp_q || (pos_q == '0);
  assign pop_o    = !empty_i && (!busy_q || (emit && last_now));

  always_comb begin
    res.speed      = speed_q;
    res.dir_flag   = dir_q;
    res.char_valid = disp_q;
    res.ascii_char = disp_q ? (ASCII_ZERO + CHAR_W'(digit)) : '0;
    res.last       = last_now;
  end

  always_comb begin
    busy_d = busy_q;
    if (pop_o) begin
      busy_d = 1'b1;
    end else if (emit && last_now) begin
      busy_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_item_q <= res;
    end
    if (pop_o) begin
      speed_q <= entry_i.speed;
      dir_q   <= entry_i.dir;
      disp_q  <= entry_i.disp;
      val_q   <= entry_i.val;
      pos_q   <= entry_i.pos;
    end else if (emit) begin
      val_q <= rem[SPEED_W-1:0];
      pos_q <= pos_q - 4'd1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

@@ hw/rtl/quadrature_speed_meter_unit.sv @@
// Quadrature speed meter: measures speed per encoder sample tick and spells it out in decimal.
// Usage:
//   Input channel: in_valid_i / in_item_i (count_now, direction_up) / in_stall_o. An item
//   is one sample tick; it is taken at a clock edge with valid high and stall low.
//   Output channel: out_valid_o / out_item_o / out_stall_i. A tick gives one result item
//   carrying speed and direction, or on every display_period-th tick one item per decimal
//   digit of the speed (leading zeros dropped, at least one digit); last marks its final item.
//   Config channel: cfg_valid_i / cfg_index_i / cfg_data_i / cfg_ready_o, always ready;
//   index 0 display_period, 1 speed_scale, 2 speed_shift. Write only while the block is idle.
// Flow:
//   The first result of a tick passes two front stages (difference, then the scale multiply),
//   a queue hop to the sequencer and the sequencer's registers before the output register.
//   The sequencer gives one result item per cycle while the output is not stalled; a tick
//   gives 1 to 5 result items; input ticks are taken every cycle while the queue has room.
// Stalls: a stalled output holds its item; the back end then stops, the queue fills and
//   in_stall_o rises once the front stages are also full.
// Reset: previous count 0, display countdown 3, display_period 3, speed_scale 600,
//   speed_shift 8; all pipeline and queue contents are dropped.
`timescale 1ns / 1ps
`default_nettype none

module quadrature_speed_meter_unit #(
  parameter int COUNT_WIDTH = qsm_pkg::COUNT_WIDTH_DEFAULT,
  parameter int QUEUE_DEPTH = qsm_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  qsm_pkg::in_item_t                  in_item_i,
  output logic                               in_stall_o,
  output logic                               out_valid_o,
  output qsm_pkg::out_item_t                 out_item_o,
  input  logic                               out_stall_i,
  input  logic                               cfg_valid_i,
  input  logic [qsm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [qsm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic                               cfg_ready_o
);
  import qsm_pkg::*;

  cfg_t   cfg_q, cfg_d;
  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_empty;
  entry_t q_in;
  entry_t q_out;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_DISPLAY_PERIOD: cfg_d.display_period = cfg_data_i[PERIOD_W-1:0];
        REG_SPEED_SCALE:    cfg_d.speed_scale    = cfg_data_i[SCALE_W-1:0];
        REG_SPEED_SHIFT:    cfg_d.speed_shift    = cfg_data_i[SHIFT_W-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.display_period <= PERIOD_RESET;
      cfg_q.speed_scale    <= SCALE_RESET;
      cfg_q.speed_shift    <= SHIFT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  qsm_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .cfg_i      (cfg_q),
    .push_o     (q_push),
    .entry_o    (q_in),
    .full_i     (q_full)
  );

  qsm_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .entry_o (q_out),
    .empty_o (q_empty)
  );

  qsm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_o       (q_pop),
    .entry_i     (q_out),
    .empty_i     (q_empty),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .out_stall_i (out_stall_i)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full || q_pop)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("queue pop while empty");

  a_plain_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.char_valid |-> out_item_o.last)
    else $error("speed-only item not marked last");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.char_valid |->
      (out_item_o.ascii_char >= ASCII_ZERO) && (out_item_o.ascii_char <= ASCII_NINE))
    else $error("display item is not a decimal digit");

endmodule

`default_nettype wire
